### design/lfut_pkg.sv
// lfut_pkg: shared constants for the LFU cache with LRU tie break.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lfut_pkg;

    // Default geometry
    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 16;

    // Capacity register
    localparam int              CAP_BITS  = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // Action codes carried in s_tuser
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // Bit positions in m_tuser
    localparam int OUT_FOUND_BIT   = 0;
    localparam int OUT_EVICTED_BIT = 1;

endpackage

### design/lfu_cache_lru_tiebreak_unit.sv
// lfu_cache_lru_tiebreak_unit: top level of the LFU cache with LRU tie break.
// Depends on lfut_pkg, lfut_match and lfut_victim.
`timescale 1ns / 1ps
//
//  Channel | Dir | Handshake         | Payload
//  --------+-----+-------------------+--------------------------------------
//  s_      | in  | s_tvalid/s_tready | tdata: key, write_value; tuser: action
//  m_      | out | m_tvalid/m_tready | tdata: read_value, evicted_key;
//          |     |                   | tuser: found, evicted
//  cfg_    | in  | cfg_wr_en         | cfg_wr_data: capacity
//
//  One item per cycle sustained while m_tready stays high. An item is loaded
//  into the input register at the accepting edge; lookup, victim tree and
//  state update then run from that register and load the result register,
//  raising m_tvalid, once that register is free or its result is taken.
//  Reset (aresetn low, synchronous) empties the store and sets capacity 16.
//  A stall on m_tready holds the result; the input register still takes one
//  more item, then s_tready drops until the result drains.

module lfu_cache_lru_tiebreak_unit #(
    parameter int ENTRIES    = lfut_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lfut_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lfut_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = lfut_pkg::COUNT_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    // cfg: capacity
    input  logic                                          cfg_wr_en,
    input  logic [lfut_pkg::CAP_BITS-1:0]                 cfg_wr_data,
    // s_tdata: key, write_value (from bit 0), zero padded to bytes
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]      s_tdata,
    // s_tuser: action
    input  logic                                          s_tuser,
    // m_tdata: read_value, evicted_key (from bit 0), zero padded to bytes
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    output logic [((VALUE_BITS+KEY_BITS+7)/8)*8-1:0]      m_tdata,
    // m_tuser: found, evicted (from bit 0)
    output logic [1:0]                                    m_tuser
);
    import lfut_pkg::*;

    localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NUM_BITS    = $clog2(ENTRIES + 1);
    localparam int CMP_BITS    = (NUM_BITS > CAP_BITS) ? NUM_BITS : CAP_BITS;
    localparam int M_DATA_BITS = ((VALUE_BITS + KEY_BITS + 7) / 8) * 8;

    // ---------------- configuration ----------------
    logic [CAP_BITS-1:0] capacity_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // ---------------- input register ----------------
    logic                  in_valid_reg;
    logic                  in_put_reg;
    logic [KEY_BITS-1:0]   in_key_reg;
    logic [VALUE_BITS-1:0] in_value_reg;
    logic                  out_valid_reg;
    logic                  advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_put_reg   <= s_tuser;
            in_key_reg   <= s_tdata[KEY_BITS-1:0];
            in_value_reg <= s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
        end
    end

    // ---------------- store ----------------
    logic [ENTRIES-1:0]                  valid_reg;
    logic [ENTRIES-1:0]                  valid_next;
    logic [ENTRIES-1:0][KEY_BITS-1:0]    key_reg;
    logic [ENTRIES-1:0][VALUE_BITS-1:0]  value_reg;
    logic [ENTRIES-1:0][COUNT_BITS-1:0]  count_reg;
    logic [ENTRIES-1:0][COUNT_BITS-1:0]  count_next;
    logic [ENTRIES-1:0][IDX_BITS-1:0]    rank_reg;
    logic [ENTRIES-1:0][IDX_BITS-1:0]    rank_next;

    logic                hit;
    logic [IDX_BITS-1:0] hit_idx;
    logic [IDX_BITS-1:0] free_idx;
    logic [NUM_BITS-1:0] fill;
    logic [IDX_BITS-1:0] victim_idx;

    lfut_match #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS),
        .IDX_BITS (IDX_BITS),
        .NUM_BITS (NUM_BITS)
    ) u_match (
        .key      (in_key_reg),
        .valid    (valid_reg),
        .keys     (key_reg),
        .hit      (hit),
        .hit_idx  (hit_idx),
        .free_idx (free_idx),
        .fill     (fill)
    );

    lfut_victim #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS),
        .IDX_BITS   (IDX_BITS)
    ) u_victim (
        .valid      (valid_reg),
        .counts     (count_reg),
        .ranks      (rank_reg),
        .victim_idx (victim_idx)
    );

    // ---------------- decision ----------------
    logic [CMP_BITS-1:0] cap_ext;
    logic [CMP_BITS-1:0] cap_eff;
    logic                cap_zero;
    logic                is_put;
    logic                do_touch;
    logic                do_insert;
    logic                do_evict;
    logic                inc_all;
    logic                update;
    logic [IDX_BITS-1:0] ref_idx;
    logic [IDX_BITS-1:0] ref_rank;
    logic                key_wr;
    logic                value_wr;

    // Capacity above the store size acts as the store size
    assign cap_ext  = CMP_BITS'(capacity_reg);
    assign cap_eff  = (cap_ext > CMP_BITS'(ENTRIES)) ? CMP_BITS'(ENTRIES) : cap_ext;
    assign cap_zero = (cap_eff == '0);
    assign is_put   = (in_put_reg == ACT_PUT);

    // Get always touches on a hit; put touches only when capacity is nonzero
    assign do_touch  = hit && (!is_put || !cap_zero);
    assign do_insert = is_put && !hit && !cap_zero;
    assign do_evict  = do_insert && (CMP_BITS'(fill) >= cap_eff);
    // Plain insert ages every valid entry; evict-and-reuse ages only the
    // entries newer than the victim, same as a touch on the victim slot
    assign inc_all   = do_insert && !do_evict;
    assign ref_idx   = hit ? hit_idx : (do_evict ? victim_idx : free_idx);
    assign ref_rank  = rank_reg[ref_idx];
    assign update    = advance && (do_touch || do_insert);
    assign key_wr    = advance && do_insert;
    assign value_wr  = advance && is_put && !cap_zero;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            valid_next[i] = valid_reg[i];
            count_next[i] = count_reg[i];
            rank_next[i]  = rank_reg[i];
            if (update) begin
                if (IDX_BITS'(i) == ref_idx) begin
                    valid_next[i] = 1'b1;
                    rank_next[i]  = '0;
                    if (do_insert) begin
                        count_next[i] = COUNT_BITS'(1);
                    end else if (count_reg[i] != '1) begin
                        count_next[i] = count_reg[i] + COUNT_BITS'(1);
                    end
                end else if (valid_reg[i] && (inc_all || rank_reg[i] < ref_rank)) begin
                    rank_next[i] = rank_reg[i] + IDX_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            rank_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (key_wr) begin
            key_reg[ref_idx] <= in_key_reg;
        end
        if (value_wr) begin
            value_reg[ref_idx] <= in_value_reg;
        end
    end

    // ---------------- result register ----------------
    logic                  found_reg;
    logic                  evicted_reg;
    logic [VALUE_BITS-1:0] read_value_reg;
    logic [KEY_BITS-1:0]   evicted_key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            found_reg       <= hit;
            evicted_reg     <= do_evict;
            read_value_reg  <= (hit && !is_put) ? value_reg[hit_idx] : '0;
            evicted_key_reg <= do_evict ? key_reg[victim_idx] : '0;
        end
    end

    assign m_tvalid                 = out_valid_reg;
    assign m_tdata                  = M_DATA_BITS'({evicted_key_reg, read_value_reg});
    assign m_tuser[OUT_FOUND_BIT]   = found_reg;
    assign m_tuser[OUT_EVICTED_BIT] = evicted_reg;

endmodule

### design/lfut_match.sv
// lfut_match: parallel key compare, first free slot and fill count.
// Depends on lfut_pkg.
`timescale 1ns / 1ps

module lfut_match #(
    parameter int ENTRIES  = lfut_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = lfut_pkg::KEY_BITS_DEF,
    parameter int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    parameter int NUM_BITS = $clog2(ENTRIES + 1)
) (
    input  logic [KEY_BITS-1:0]                key,
    input  logic [ENTRIES-1:0]                 valid,
    input  logic [ENTRIES-1:0][KEY_BITS-1:0]   keys,
    output logic                               hit,
    output logic [IDX_BITS-1:0]                hit_idx,
    output logic [IDX_BITS-1:0]                free_idx,
    output logic [NUM_BITS-1:0]                fill
);
    import lfut_pkg::*;

    logic [ENTRIES-1:0] match;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = valid[i] && (keys[i] == key);
        end
    end

    // Walk downward so the lowest index wins
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IDX_BITS'(i);
            end
            if (!valid[i]) begin
                free_idx = IDX_BITS'(i);
            end
        end
    end

    assign hit  = |match;
    assign fill = NUM_BITS'($countones(valid));

endmodule

### design/lfut_victim.sv
// lfut_victim: minimum tree over use count, then oldest recency rank.
// Depends on lfut_pkg.
`timescale 1ns / 1ps

module lfut_victim #(
    parameter int ENTRIES    = lfut_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfut_pkg::COUNT_BITS_DEF,
    parameter int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic [ENTRIES-1:0]                  valid,
    input  logic [ENTRIES-1:0][COUNT_BITS-1:0]  counts,
    input  logic [ENTRIES-1:0][IDX_BITS-1:0]    ranks,
    output logic [IDX_BITS-1:0]                 victim_idx
);
    import lfut_pkg::*;

    localparam int LEAVES = 1 << IDX_BITS;

    logic                  node_vld [2*LEAVES];
    logic [COUNT_BITS-1:0] node_cnt [2*LEAVES];
    logic [IDX_BITS-1:0]   node_rnk [2*LEAVES];
    logic [IDX_BITS-1:0]   node_idx [2*LEAVES];

    always_comb begin
        node_vld[0] = 1'b0;
        node_cnt[0] = '0;
        node_rnk[0] = '0;
        node_idx[0] = '0;
        for (int j = 0; j < LEAVES; j++) begin
            if (j < ENTRIES) begin
                node_vld[LEAVES+j] = valid[j];
                node_cnt[LEAVES+j] = counts[j];
                node_rnk[LEAVES+j] = ranks[j];
            end else begin
                node_vld[LEAVES+j] = 1'b0;
                node_cnt[LEAVES+j] = '0;
                node_rnk[LEAVES+j] = '0;
            end
            node_idx[LEAVES+j] = IDX_BITS'(j);
        end
        // Right child wins only when strictly better: lower count, or same
        // count and older (higher rank).
        for (int k = LEAVES - 1; k >= 1; k--) begin
            if (node_vld[2*k+1] && (!node_vld[2*k] ||
                    node_cnt[2*k+1] < node_cnt[2*k] ||
                    (node_cnt[2*k+1] == node_cnt[2*k] &&
                     node_rnk[2*k+1] > node_rnk[2*k]))) begin
                node_vld[k] = 1'b1;
                node_cnt[k] = node_cnt[2*k+1];
                node_rnk[k] = node_rnk[2*k+1];
                node_idx[k] = node_idx[2*k+1];
            end else begin
                node_vld[k] = node_vld[2*k];
                node_cnt[k] = node_cnt[2*k];
                node_rnk[k] = node_rnk[2*k];
                node_idx[k] = node_idx[2*k];
            end
        end
    end

    assign victim_idx = node_idx[1];

endmodule

### design/lfut_checker.sv
// lfut_checker: port-level assertions for the LFU cache top level.
// Depends on lfut_pkg; bound to lfu_cache_lru_tiebreak_unit below.
`timescale 1ns / 1ps

module lfut_checker #(
    parameter int KEY_BITS   = lfut_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lfut_pkg::VALUE_BITS_DEF
) (
    input logic                                      aclk,
    input logic                                      aresetn,
    input logic                                      m_tvalid,
    input logic                                      m_tready,
    input logic [((VALUE_BITS+KEY_BITS+7)/8)*8-1:0]  m_tdata,
    input logic [1:0]                                m_tuser
);
    import lfut_pkg::*;

    logic                  found;
    logic                  evicted;
    logic [VALUE_BITS-1:0] read_value;
    logic [KEY_BITS-1:0]   evicted_key;

    assign found       = m_tuser[OUT_FOUND_BIT];
    assign evicted     = m_tuser[OUT_EVICTED_BIT];
    assign read_value  = m_tdata[VALUE_BITS-1:0];
    assign evicted_key = m_tdata[VALUE_BITS+KEY_BITS-1:VALUE_BITS];

    // Eviction only happens on a put miss
    a_evict_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && evicted |-> !found && read_value == '0)
        else $error("eviction reported together with a hit or read data");

    a_evict_key_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !evicted |-> evicted_key == '0)
        else $error("evicted_key nonzero without eviction");

    a_data_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && read_value != '0 |-> found)
        else $error("read data returned on a miss");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind lfu_cache_lru_tiebreak_unit lfut_checker #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
) u_lfut_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### verif/tb_top.sv
// tb_top: self-checking testbench for lfu_cache_lru_tiebreak_unit.
// Runs a transaction-level model of the LFU/LRU store against the DUT item by item.
// Depends on lfut_pkg and the design sources only.
`timescale 1ns / 1ps

module tb_top;
    import lfut_pkg::*;

    localparam int NUM_ENTRIES  = ENTRIES_DEF;
    localparam int IDLE_LIMIT   = 2000;   // cycles with no item moving on either side
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic        found;
        logic [31:0] read_value;
        logic        evicted;
        logic [15:0] evicted_key;
    } cache_resp_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [CAP_BITS-1:0] cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [47:0]         s_tdata;    // key[15:0], write_value[47:16]
    logic                s_tuser;    // action
    logic                m_tvalid;
    logic                m_tready;
    logic [47:0]         m_tdata;    // read_value[31:0], evicted_key[47:32]
    logic [1:0]          m_tuser;    // found[0], evicted[1]

    lfu_cache_lru_tiebreak_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------
    // Store model: one copy of the entry table and the capacity register
    // ------------------------------------------------------------------
    logic [CAP_BITS-1:0] cap_reg;
    bit                  cache_valid [NUM_ENTRIES];
    logic [15:0]         cache_key   [NUM_ENTRIES];
    logic [31:0]         cache_val   [NUM_ENTRIES];
    logic [15:0]         cache_hits  [NUM_ENTRIES];
    int unsigned         cache_age   [NUM_ENTRIES];   // 0 = most recent

    cache_resp_t resp_q[$];

    int unsigned err_count;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned hits_seen;
    int unsigned evicts_seen;
    int unsigned cap_writes;
    bit          quiet_mode;   // no idling on either side

    task automatic model_reset();
        cap_reg = CAP_RESET;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            cache_valid[i] = 1'b0;
            cache_key[i]   = '0;
            cache_val[i]   = '0;
            cache_hits[i]  = '0;
            cache_age[i]   = 0;
        end
    endtask

    // Hit: move entry to front of the recency order, bump its count (saturating).
    task automatic touch_entry(input int e);
        int unsigned r;
        r = cache_age[e];
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (cache_valid[i] && cache_age[i] < r)
                cache_age[i]++;
        cache_age[e] = 0;
        if (cache_hits[e] < COUNT_MAX)
            cache_hits[e]++;
    endtask

    task automatic cache_access(input logic act, input logic [15:0] k, input logic [31:0] v,
                                output cache_resp_t resp);
        int          hit;
        int          held;
        int          slot;
        int          vic;
        int unsigned eff_cap;
        int unsigned vic_age;
        hit  = -1;
        held = 0;
        slot = -1;
        vic  = -1;
        resp = '0;
        eff_cap = (cap_reg > NUM_ENTRIES) ? NUM_ENTRIES : cap_reg;

        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (cache_valid[i]) begin
                held++;
                if (hit < 0 && cache_key[i] == k)
                    hit = i;
            end
        end
        resp.found = (hit >= 0);

        if (act == ACT_GET) begin
            if (hit >= 0) begin
                touch_entry(hit);
                resp.read_value = cache_val[hit];
            end
        end else if (eff_cap == 0) begin
            // inserts disabled: nothing changes
        end else if (hit >= 0) begin
            touch_entry(hit);
            cache_val[hit] = v;
        end else begin
            if (held >= eff_cap) begin
                // lowest count wins, ties go to the oldest
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (!cache_valid[i])
                        continue;
                    if (vic < 0 || cache_hits[i] < cache_hits[vic] ||
                        (cache_hits[i] == cache_hits[vic] && cache_age[i] > cache_age[vic]))
                        vic = i;
                end
                if (vic >= 0) begin
                    vic_age = cache_age[vic];
                    cache_valid[vic] = 1'b0;
                    for (int i = 0; i < NUM_ENTRIES; i++)
                        if (cache_valid[i] && cache_age[i] > vic_age)
                            cache_age[i]--;
                    resp.evicted     = 1'b1;
                    resp.evicted_key = cache_key[vic];
                    slot = vic;
                end
            end
            if (slot < 0) begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                    if (!cache_valid[i]) begin
                        slot = i;
                        break;
                    end
            end
            if (slot >= 0) begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                    if (cache_valid[i])
                        cache_age[i]++;
                cache_valid[slot] = 1'b1;
                cache_key[slot]   = k;
                cache_val[slot]   = v;
                cache_hits[slot]  = 16'd1;
                cache_age[slot]   = 0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cache_resp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (resp_q.size() == 0) begin
                $display("%0t ERROR unexpected result tdata=%h tuser=%b",
                         $time, m_tdata, m_tuser);
                err_count++;
            end else begin
                want = resp_q[0];
                resp_q.delete(0);
                if (want.found) hits_seen++;
                if (want.evicted) evicts_seen++;
                if (m_tuser[OUT_FOUND_BIT] !== want.found) begin
                    $display("%0t ERROR found exp=%b act=%b",
                             $time, want.found, m_tuser[OUT_FOUND_BIT]);
                    err_count++;
                end
                if (m_tdata[31:0] !== want.read_value) begin
                    $display("%0t ERROR read_value exp=%h act=%h",
                             $time, want.read_value, m_tdata[31:0]);
                    err_count++;
                end
                if (m_tuser[OUT_EVICTED_BIT] !== want.evicted) begin
                    $display("%0t ERROR evicted exp=%b act=%b",
                             $time, want.evicted, m_tuser[OUT_EVICTED_BIT]);
                    err_count++;
                end
                if (m_tdata[47:32] !== want.evicted_key) begin
                    $display("%0t ERROR evicted_key exp=%h act=%h",
                             $time, want.evicted_key, m_tdata[47:32]);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: too long with nothing moving means the DUT is hung.
    int unsigned stuck_cycles;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= IDLE_LIMIT) begin
            $display("%0t ERROR timeout, %0d results still pending", $time, resp_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // Result side backpressure: random stall bursts of random length.
    initial begin
        int len;
        m_tready = 1'b0;
        forever begin
            if (quiet_mode || !aresetn) begin
                @(negedge aclk);
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                len = $urandom_range(1, 7);
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (len - 1) @(negedge aclk);
            end else begin
                len = $urandom_range(0, 10);
                @(negedge aclk);
                m_tready <= 1'b1;
                repeat (len) @(negedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Present one item and hold it until accepted; valid stays high afterward.
    task automatic send_item(input logic act, input logic [15:0] k, input logic [31:0] v);
        cache_resp_t resp;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {v, k};
        do @(posedge aclk); while (!s_tready);
        cache_access(act, k, v, resp);
        resp_q.push_back(resp);
        items_sent++;
    endtask

    task automatic idle_input(input int cycles);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic maybe_gap();
        if (!quiet_mode && $urandom_range(0, 3) == 0)
            idle_input($urandom_range(1, 7));
    endtask

    // Stop sending and wait for every predicted result, plus a short hold-off.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (resp_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
        drain_results();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cap_reg = cap;
        cap_writes++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Extremes of key and value, get miss, put hit, get hit.
    task automatic test_basic_access();
        send_item(ACT_GET, 16'h0000, 32'hFFFF_FFFF);   // miss on empty store
        send_item(ACT_PUT, 16'h0000, 32'h0000_0000);
        send_item(ACT_PUT, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(ACT_GET, 16'hFFFF, 32'h0000_0000);
        send_item(ACT_GET, 16'h0000, 32'h1234_5678);
        send_item(ACT_PUT, 16'h0000, 32'hA5A5_5A5A);   // put hit replaces value
        send_item(ACT_GET, 16'h0000, 32'h0);
        send_item(ACT_GET, 16'h8001, 32'h0);           // miss with entries present
    endtask

    // Lowest count goes first; equal counts fall back to least recent.
    task automatic test_lfu_lru_eviction();
        write_capacity(5'd3);   // store already holds two keys
        send_item(ACT_PUT, 16'h0101, 32'h1111_1111);
        send_item(ACT_PUT, 16'h0202, 32'h2222_2222);   // full: evicts count-1 LRU
        send_item(ACT_GET, 16'h0101, 32'h0);
        send_item(ACT_PUT, 16'h0303, 32'h3333_3333);
        send_item(ACT_PUT, 16'h0404, 32'h4444_4444);
        write_capacity(5'd1);   // shrink below held count
        send_item(ACT_PUT, 16'h0505, 32'h5555_5555);
        send_item(ACT_PUT, 16'h0606, 32'h6666_6666);
    endtask

    // Zero capacity: puts are no-ops, gets still hit and touch.
    task automatic test_capacity_zero();
        write_capacity(5'd0);
        send_item(ACT_PUT, 16'h0606, 32'hDEAD_BEEF);   // hit, value kept
        send_item(ACT_PUT, 16'h7777, 32'h7777_7777);   // miss, nothing inserted
        send_item(ACT_GET, 16'h0606, 32'h0);
        send_item(ACT_GET, 16'h7777, 32'h0);
        write_capacity(5'd31);                          // clamps to entry count
        send_item(ACT_PUT, 16'h7777, 32'h0F0F_0F0F);
        send_item(ACT_GET, 16'h7777, 32'h0);
    endtask

    // One random phase: mostly keys from a small pool (hits, evictions), some
    // fully random keys as noise.
    task automatic random_phase(input logic [CAP_BITS-1:0] cap, input int n_items,
                                input int pool_size, input bit pause_midway);
        logic [15:0] key_pool[$];
        logic [15:0] k;
        logic        act;
        write_capacity(cap);
        for (int i = 0; i < pool_size; i++)
            key_pool.push_back(16'($urandom));
        for (int i = 0; i < n_items; i++) begin
            act = ($urandom_range(0, 99) < 55) ? ACT_PUT : ACT_GET;
            if ($urandom_range(0, 99) < 85)
                k = key_pool[$urandom_range(0, pool_size - 1)];
            else
                k = 16'($urandom);
            maybe_gap();
            send_item(act, k, $urandom);
            if (pause_midway && i == n_items / 2)
                drain_results();
        end
    endtask

    task automatic test_random_traffic();
        random_phase(5'd16, 90, 24, 1'b1);
        random_phase(5'd3, 60, 6, 1'b0);    // shrink with a full store
        random_phase(5'd0, 30, 8, 1'b0);
        random_phase(5'd1, 50, 3, 1'b0);
        random_phase(5'd31, 70, 22, 1'b0);
        random_phase(5'($urandom_range(2, 15)), 80, 12, 1'b1);
        random_phase(5'd17, 60, 20, 1'b0);
        quiet_mode = 1'b1;                  // last stretch runs flat out
        random_phase(5'd8, 80, 12, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = ACT_GET;
        err_count    = 0;
        items_sent   = 0;
        results_seen = 0;
        hits_seen    = 0;
        evicts_seen  = 0;
        cap_writes   = 0;
        stuck_cycles = 0;
        quiet_mode   = 1'b0;
        model_reset();

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_basic_access();
        test_lfu_lru_eviction();
        test_capacity_zero();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge aclk);

        $display("run covered %0d items, %0d results, %0d hits, %0d evictions",
                 items_sent, results_seen, hits_seen, evicts_seen);
        $display("%0d capacity writes incl. zero, one and clamp values",
                 cap_writes);
        if (err_count == 0 && resp_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
design/lfut_pkg.sv
design/lfut_match.sv
design/lfut_victim.sv
design/lfu_cache_lru_tiebreak_unit.sv
design/lfut_checker.sv
verif/tb_top.sv
